### rtl/bsc_pkg.sv
// bsc_pkg: shared types and constants for the bubble sort with swap count block
// no dependencies; imported by every module of the block
package bsc_pkg;

   localparam int KEY_W      = 32;
   localparam int SIZE_W     = 5;
   localparam int SWAP_W     = 7;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;

   localparam logic [SIZE_W-1:0] SET_SIZE_RESET = 5'd16;
   localparam logic [SWAP_W-1:0] SWAP_MAX       = 7'd127;

   // one queued key and whether it closes its set
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic                    last;
   } bsc_entry_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } bsc_back_state_type;

endpackage

### rtl/bubble_sort_with_swap_count_top.sv
// bubble_sort_with_swap_count_top: top level of the key sorter
// depends on bsc_pkg, bsc_front, bsc_fifo and bsc_back
//
// Keys come in on the req_ channel, one signed 32-bit key per transaction.
// Once a set of N keys has arrived (N from the set size register, written
// through csr_wr_en/csr_wr_data; 0 counts as 1, sizes above the store depth
// as the depth), the set is sorted ascending and leaves on the rsp_ channel
// as N transactions, each with the set's adjacent-swap count, the last one
// flagged by rsp_last_of_set.
// Flow per set: keys are accepted one per cycle while req_ready is high into a
// 4-entry queue, the back end moves one key per cycle into its store, sorts
// by odd-even transposition (one phase per cycle), then emits one key per
// cycle while rsp_ready is high. The back end works on one set at a time
// through its single store and sorter. While it sorts or emits, up to four
// keys of the next set wait in the queue; req_ready falls when it is full.
// If the receiver holds rsp_ready low, the current result holds and the
// back end waits. Reset sets the set size to 16 and clears all counts.
module bubble_sort_with_swap_count_top #(
   parameter int STORE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [bsc_pkg::SIZE_W-1:0]         csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [bsc_pkg::KEY_W-1:0]   req_key_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [bsc_pkg::KEY_W-1:0]   rsp_sorted_key,
   output logic [bsc_pkg::SWAP_W-1:0]         rsp_swap_count,
   output logic                               rsp_last_of_set
);
   import bsc_pkg::*;

   logic          push_valid, push_ready, pop_valid, pop_ready;
   bsc_entry_type push_entry, pop_entry;

   bsc_front #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_key_value (req_key_value),
      .push_valid    (push_valid),
      .push_entry    (push_entry),
      .push_ready    (push_ready)
   );

   bsc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   bsc_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sorted_key  (rsp_sorted_key),
      .rsp_swap_count  (rsp_swap_count),
      .rsp_last_of_set (rsp_last_of_set)
   );

   // a set leaves without gaps
   a_set_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_set |=> rsp_valid)
      else $error("gap inside an emitted set");

   // back end returns to loading after the last key
   a_set_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_set |=> !rsp_valid)
      else $error("result shown right after end of set");

   // keys of a set come out ascending
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_set |=>
         rsp_sorted_key >= $past(rsp_sorted_key))
      else $error("emitted keys out of order");

   // one swap count for the whole set
   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_set |=>
         rsp_swap_count == $past(rsp_swap_count))
      else $error("swap count changed within a set");

endmodule

### rtl/bsc_front.sv
// bsc_front: holds the set size register, counts keys of the current set
// and tags the key that closes it; depends on bsc_pkg
module bsc_front #(
   parameter int STORE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [bsc_pkg::SIZE_W-1:0]         csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [bsc_pkg::KEY_W-1:0]   req_key_value,
   output logic                               push_valid,
   output bsc_pkg::bsc_entry_type             push_entry,
   input  logic                               push_ready
);
   import bsc_pkg::*;

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CMP_W-1:0]  size_ext, eff_size, cnt_next;
   logic              closes_set;

   // zero acts as one, anything above the store depth acts as the depth
   always_comb begin
      size_ext = CMP_W'(size_ff);
      if (size_ff == '0) begin
         eff_size = CMP_W'(1);
      end else if (size_ext > CMP_W'(STORE_DEPTH)) begin
         eff_size = CMP_W'(STORE_DEPTH);
      end else begin
         eff_size = size_ext;
      end
   end

   always_comb begin
      cnt_next   = CMP_W'(cnt_ff) + CMP_W'(1);
      closes_set = (cnt_next >= eff_size);
      size_in    = csr_wr_en ? csr_wr_data : size_ff;
      cnt_in     = cnt_ff;
      if (req_valid && req_ready) begin
         cnt_in = closes_set ? '0 : CNT_W'(cnt_next);
      end
   end

   assign req_ready       = push_ready;
   assign push_valid      = req_valid;
   assign push_entry.key  = req_key_value;
   assign push_entry.last = closes_set;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SET_SIZE_RESET;
         cnt_ff  <= '0;
      end else begin
         size_ff <= size_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

### rtl/bsc_fifo.sv
// bsc_fifo: short queue of tagged keys between front and back
// depends on bsc_pkg
module bsc_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  bsc_pkg::bsc_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output bsc_pkg::bsc_entry_type pop_entry
);
   import bsc_pkg::*;

   bsc_entry_type           slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     fill_ff, fill_in;
   logic                    do_push, do_pop;

   assign push_ready = (fill_ff != (FIFO_PTR_W + 1)'(FIFO_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (FIFO_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (FIFO_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/bsc_back.sv
// bsc_back: key store, odd-even transposition sorter with swap counter
// and shift-out emission; depends on bsc_pkg
module bsc_back #(
   parameter int STORE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  bsc_pkg::bsc_entry_type             pop_entry,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [bsc_pkg::KEY_W-1:0]   rsp_sorted_key,
   output logic [bsc_pkg::SWAP_W-1:0]         rsp_swap_count,
   output logic                               rsp_last_of_set
);
   import bsc_pkg::*;

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int SUM_W = SWAP_W + 1;

   bsc_back_state_type      state_ff, state_in;
   logic signed [KEY_W-1:0] key_ff [STORE_DEPTH];
   logic signed [KEY_W-1:0] key_in [STORE_DEPTH];
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        phase_ff, phase_in;
   logic [SWAP_W-1:0]       swap_ff, swap_in;
   logic [STORE_DEPTH-2:0]  swap_vec;
   logic [SUM_W-1:0]        swap_sum;
   logic                    sort_done, load_last, emit_take, emit_last;

   // compare-and-swap lanes; even pairs on even phases, odd pairs on odd ones
   for (genvar i = 0; i < STORE_DEPTH - 1; i++) begin : g_lane
      localparam logic PAR = (i % 2) == 1;
      assign swap_vec[i] = (phase_ff[0] == PAR) && (CNT_W'(i + 1) < cnt_ff)
                           && (key_ff[i] > key_ff[i + 1]);
   end

   assign sort_done = (phase_ff == cnt_ff - CNT_W'(1));
   assign load_last = pop_valid && pop_ready && pop_entry.last;
   assign emit_last = (cnt_ff == CNT_W'(1));
   assign emit_take = rsp_valid && rsp_ready;
   assign swap_sum  = SUM_W'(swap_ff) + SUM_W'($countones(swap_vec));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_last) begin
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            if (sort_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_take && emit_last) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD: pop_ready = 1'b1;
         ST_SORT: pop_ready = 1'b0;
         ST_EMIT: rsp_valid = 1'b1;
         default: begin
            pop_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign rsp_sorted_key  = key_ff[0];
   assign rsp_swap_count  = swap_ff;
   assign rsp_last_of_set = emit_last;

   // datapath
   always_comb begin
      key_in   = key_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      swap_in  = swap_ff;
      case (state_ff)
         ST_LOAD: begin
            phase_in = '0;
            swap_in  = '0;
            if (pop_valid) begin
               key_in[cnt_ff[IDX_W-1:0]] = pop_entry.key;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SORT: begin
            for (int i = 0; i < STORE_DEPTH - 1; i++) begin
               if (swap_vec[i]) begin
                  key_in[i]     = key_ff[i + 1];
                  key_in[i + 1] = key_ff[i];
               end
            end
            phase_in = phase_ff + CNT_W'(1);
            // saturate the count
            swap_in  = (swap_sum > SUM_W'(SWAP_MAX)) ? SWAP_MAX : SWAP_W'(swap_sum);
         end
         ST_EMIT: begin
            if (emit_take) begin
               for (int i = 0; i < STORE_DEPTH - 1; i++) begin
                  key_in[i] = key_ff[i + 1];
               end
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         phase_ff <= '0;
         swap_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         swap_ff  <= swap_in;
      end
   end

endmodule
